FILE: src/sar_pkg.sv
// ----------------------------------------------------------------------------
// sar_pkg
// Shared types and constants for the segment address relocator.
// ----------------------------------------------------------------------------
package sar_pkg;

	localparam int MAX_SEGMENTS = 8;
	localparam int SLOT_W       = 3;
	localparam int COUNT_W      = 4;
	localparam int ADDR_W       = 32;

	localparam logic [ADDR_W-1:0] MISS_ADDRESS = '1;

	localparam logic KIND_LOAD      = 1'b0;
	localparam logic KIND_TRANSLATE = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_ADD  = 3'b100
	} sar_state_t;

endpackage

FILE: src/segment_address_relocator.sv
// ----------------------------------------------------------------------------
// segment_address_relocator
// Relocates a link-time address through a small load map of segments,
// scanning one slot per cycle with a single shared 33-bit adder.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   kind, slot_index, load_base,
//                                            link_base, segment_size,
//                                            query_address
//  out      output     out_valid / out_stall mapped_address, hit
//  cfg      input      cfg_wr_en             cfg_wr_data (segment count)
//
//  a load transaction is answered from ST_IDLE; a translate scans k slots
//  (at most 8) in ST_SCAN, with ST_ADD after it on a hit, the slot loop going
//  through the shared adder, one slot read per cycle from the table memory.
//  in_stall is high while a translate is in progress and while a finished
//  result is held by out_stall. reset clears the segment count and control
//  state; table contents are undefined until written.
module segment_address_relocator
	import sar_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [SLOT_W-1:0]  slot_index,
	input  addr_t              load_base,
	input  addr_t              link_base,
	input  addr_t              segment_size,
	input  addr_t              query_address,
	output logic               out_valid,
	input  logic               out_stall,
	output addr_t              mapped_address,
	output logic               hit,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data
);

	addr_t load_mem [MAX_SEGMENTS];
	addr_t link_mem [MAX_SEGMENTS];
	addr_t size_mem [MAX_SEGMENTS];

	sar_state_t          state_q;
	logic [COUNT_W-1:0]  count_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   rd_addr;
	addr_t               rd_load_q, rd_link_q, rd_size_q;
	addr_t               query_q, offset_q, base_q;
	logic                out_valid_q, hit_q;
	addr_t               mapped_q;

	logic [COUNT_W-1:0]  eff_count;
	logic [SLOT_W-1:0]   last_idx;
	logic                accept, out_free;
	addr_t               add_a, add_b;
	logic                add_cin;
	logic [ADDR_W:0]     add_sum;
	logic                above_base, in_seg, is_last;
	logic                res_we, res_hit;
	addr_t               res_addr;

	assign eff_count = (count_q > COUNT_W'(MAX_SEGMENTS)) ? COUNT_W'(MAX_SEGMENTS) : count_q;
	assign last_idx  = SLOT_W'(eff_count - COUNT_W'(1));
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;

	// shared adder: query - link base while scanning, load base + offset at the end
	always_comb begin
		if (state_q == ST_ADD) begin
			add_a   = base_q;
			add_b   = offset_q;
			add_cin = 1'b0;
		end else begin
			add_a   = query_q;
			add_b   = ~rd_link_q;
			add_cin = 1'b1;
		end
	end
	assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{ADDR_W{1'b0}}, add_cin};

	assign above_base = add_sum[ADDR_W];
	assign is_last    = (idx_q == last_idx);
	assign in_seg     = (add_sum[ADDR_W-1:0] < rd_size_q)
		|| ((add_sum[ADDR_W-1:0] == rd_size_q) && is_last);

	assign rd_addr = (state_q == ST_SCAN) ? idx_q + SLOT_W'(1) : '0;

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && kind == KIND_LOAD) begin
			load_mem[slot_index] <= load_base;
			link_mem[slot_index] <= link_base;
			size_mem[slot_index] <= segment_size;
		end
		rd_load_q <= load_mem[rd_addr];
		rd_link_q <= link_mem[rd_addr];
		rd_size_q <= size_mem[rd_addr];
	end

	// result write into the output register
	always_comb begin
		res_we   = 1'b0;
		res_hit  = 1'b0;
		res_addr = MISS_ADDRESS;
		case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_LOAD || eff_count == '0))
					res_we = 1'b1;
			end
			ST_SCAN: begin
				if (!above_base || (!in_seg && is_last))
					res_we = 1'b1;
			end
			ST_ADD: begin
				res_we   = 1'b1;
				res_hit  = 1'b1;
				res_addr = add_sum[ADDR_W-1:0];
			end
			default: begin
				res_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				count_q <= cfg_wr_data;
			if (res_we)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept && kind == KIND_TRANSLATE && eff_count != '0)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!above_base)
						state_q <= ST_IDLE;
					else if (in_seg)
						state_q <= ST_ADD;
					else if (is_last)
						state_q <= ST_IDLE;
					else
						idx_q <= idx_q + SLOT_W'(1);
				end
				ST_ADD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			query_q <= query_address;
		if (state_q == ST_SCAN) begin
			offset_q <= add_sum[ADDR_W-1:0];
			base_q   <= rd_load_q;
		end
		if (res_we) begin
			mapped_q <= res_addr;
			hit_q    <= res_hit;
		end
	end

	assign out_valid      = out_valid_q;
	assign mapped_address = mapped_q;
	assign hit            = hit_q;

endmodule

FILE: src/sar_checker.sv
// ----------------------------------------------------------------------------
// sar_checker
// Port-level checks for the segment address relocator, bound to the top.
// ----------------------------------------------------------------------------
module sar_checker
	import sar_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_stall,
	input logic  kind,
	input logic  out_valid,
	input logic  out_stall,
	input addr_t mapped_address,
	input logic  hit
);

	// a held result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out transaction dropped while stalled");

	// a miss always reports the all-ones address
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> mapped_address == MISS_ADDRESS)
		else $error("miss without all-ones address");

	// a load transaction answers in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_LOAD |=> out_valid && !hit)
		else $error("load transaction without miss result");

	// no new transaction is taken while a result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output held");

endmodule

bind segment_address_relocator sar_checker u_sar_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.kind           (kind),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.mapped_address (mapped_address),
	.hit            (hit)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_address_relocator. It loads sorted segment
// maps, steps the segment count through its extremes and translates addresses
// around segment edges. Every result is checked against an in-bench load map.
// ----------------------------------------------------------------------------
module tb;
	import sar_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TARGET_ITEMS   = 2000;

	class relocation_model;
		typedef struct {
			addr_t addr;
			logic  hit;
		} answer_t;

		addr_t load_tbl [MAX_SEGMENTS];
		addr_t link_tbl [MAX_SEGMENTS];
		addr_t size_tbl [MAX_SEGMENTS];
		logic [COUNT_W-1:0] seg_count = '0;
		answer_t pending_answers[$];
		int errors = 0;
		int loads = 0;
		int translations = 0;
		int hits = 0;

		function int pending();
			return pending_answers.size();
		endfunction

		function void note_input(logic k, logic [SLOT_W-1:0] slot, addr_t lbase,
				addr_t vbase, addr_t size, addr_t query);
			answer_t a;
			int n;
			addr_t off;
			a.addr = MISS_ADDRESS;
			a.hit  = 1'b0;
			if (k == KIND_LOAD) begin
				load_tbl[slot] = lbase;
				link_tbl[slot] = vbase;
				size_tbl[slot] = size;
				loads++;
			end else begin
				n = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
				translations++;
				// scan stops at the first slot whose link base lies above the query
				for (int i = 0; i < n; i++) begin
					if (query < link_tbl[i])
						break;
					off = query - link_tbl[i];
					if (off < size_tbl[i] || (off == size_tbl[i] && i == n - 1)) begin
						a.addr = load_tbl[i] + off;
						a.hit  = 1'b1;
						break;
					end
				end
			end
			pending_answers.push_back(a);
		endfunction

		function void check_result(addr_t addr, logic hit_bit);
			answer_t a;
			if (pending_answers.size() == 0) begin
				$error("result with no transaction outstanding: mapped_address %h hit %b",
					addr, hit_bit);
				errors++;
				return;
			end
			a = pending_answers.pop_front();
			if (addr !== a.addr) begin
				$error("mapped_address: expected %h, got %h", a.addr, addr);
				errors++;
			end
			if (hit_bit !== a.hit) begin
				$error("hit: expected %b, got %b", a.hit, hit_bit);
				errors++;
			end
			if (a.hit)
				hits++;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = KIND_LOAD;
	logic [SLOT_W-1:0]  slot_index = '0;
	addr_t              load_base = '0;
	addr_t              link_base = '0;
	addr_t              segment_size = '0;
	addr_t              query_address = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	addr_t              mapped_address;
	logic               hit;
	logic               cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;

	relocation_model load_map;
	bit calm = 1'b0;
	int items_sent = 0;
	int count_settings = 0;
	int idle_cycles = 0;

	segment_address_relocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.slot_index     (slot_index),
		.load_base      (load_base),
		.link_base      (link_base),
		.segment_size   (segment_size),
		.query_address  (query_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mapped_address (mapped_address),
		.hit            (hit),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one process sees config, input and output of an edge, so ordering is fixed
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				load_map.seg_count = cfg_wr_data;
			if (in_valid && !in_stall)
				load_map.note_input(kind, slot_index, load_base, link_base,
					segment_size, query_address);
			if (out_valid && !out_stall)
				load_map.check_result(mapped_address, hit);
			if (cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int n;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 16);
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
				@(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// valid stays high after acceptance; the next call either reloads or drops it
	task automatic send(input logic k, input logic [SLOT_W-1:0] s,
			input addr_t lb, vb, sz, q);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		kind          <= k;
		slot_index    <= s;
		load_base     <= lb;
		link_base     <= vb;
		segment_size  <= sz;
		query_address <= q;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic load_slot(input logic [SLOT_W-1:0] s, input addr_t lb, vb, sz);
		send(KIND_LOAD, s, lb, vb, sz, $urandom());
	endtask

	task automatic translate(input addr_t q);
		send(KIND_TRANSLATE, SLOT_W'($urandom()), $urandom(), $urandom(), $urandom(), q);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (load_map.pending() != 0) @(negedge clk);
	endtask

	task automatic set_count(input logic [COUNT_W-1:0] n);
		wait_idle();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= n;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		count_settings++;
	endtask

	task automatic run_directed();
		// empty map: nothing is scanned, so unwritten slots are never touched
		translate(32'h0000_0000);
		translate(32'hFFFF_FFFF);
		load_slot(3'd0, 32'h8000_0000, 32'h0000_1000, 32'h0000_0100);
		load_slot(3'd1, 32'h0000_0000, 32'h0000_2000, 32'h0000_0800);
		load_slot(3'd2, 32'hFFFF_FFF0, 32'h0001_0000, 32'h0000_0040);
		load_slot(3'd3, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_0010);
		load_slot(3'd4, 32'h1234_5678, 32'h1000_0000, 32'h0000_0000);
		load_slot(3'd5, 32'h4000_0000, 32'h2000_0000, 32'h0000_1000);
		load_slot(3'd6, 32'h5000_0000, 32'h8000_0000, 32'h0000_0100);
		load_slot(3'd7, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_FFFF);
		set_count(4'd8);
		translate(32'h0000_0FFF);  // below the first segment
		translate(32'h0000_1000);
		translate(32'h0000_10FF);
		translate(32'h0000_1100);  // end of a segment that is not the last
		translate(32'h0001_0020);  // relocated address wraps
		translate(32'h0002_0000);  // hit that yields all ones
		translate(32'h1000_0000);  // zero-size segment
		translate(32'hFFFF_FFFF);  // end of the last segment
		set_count(4'd15);          // saturates to the table depth
		translate(32'hFFFF_FFFF);
		set_count(4'd3);
		translate(32'h0001_0040);  // end of the last valid segment
	endtask

	task automatic load_map_sorted();
		addr_t cursor, vb, sz;
		cursor = ($urandom_range(0, 3) == 0) ? '0 : ($urandom() >> $urandom_range(1, 12));
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			vb = cursor + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4096));
			case ($urandom_range(0, 5))
				0: sz = '0;
				1: sz = $urandom() >> $urandom_range(4, 8);
				default: sz = $urandom_range(1, 4096);
			endcase
			load_slot(SLOT_W'(i), $urandom(), vb, sz);
			cursor = vb + sz;
		end
	endtask

	// queries cluster on segment edges, where the interesting decisions are
	function automatic addr_t aim_query();
		int s;
		addr_t vb, sz;
		s  = $urandom_range(0, MAX_SEGMENTS - 1);
		vb = load_map.link_tbl[s];
		sz = load_map.size_tbl[s];
		case ($urandom_range(0, 7))
			0: return vb - 1;
			1: return vb;
			2: return vb + sz - 1;
			3: return vb + sz;
			4: return vb + sz + 1;
			5: return $urandom();
			default: return vb + ((sz == '1) ? $urandom() : ($urandom() % (sz + 1)));
		endcase
	endfunction

	task automatic run_random();
		int phase;
		int burst;
		int pick;
		logic [COUNT_W-1:0] n;
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			case (phase)
				0: n = 4'd8;
				1: n = 4'd15;
				2: n = 4'd0;
				3: n = 4'd1;
				4: n = 4'd9;
				default: n = $urandom_range(0, 15);
			endcase
			calm = ($urandom_range(0, 3) == 0);
			set_count(n);
			burst = $urandom_range(60, 140);
			for (int j = 0; j < burst; j++) begin
				pick = $urandom_range(0, 99);
				if (pick < 6)
					load_map_sorted();
				else if (pick < 14)
					load_slot(SLOT_W'($urandom()), $urandom(), $urandom(), $urandom());
				else if (pick < 16)
					wait_idle();
				else
					translate(aim_query());
			end
			phase++;
		end
	endtask

	initial begin
		load_map = new;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		calm = 1'b0;
		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d slot loads and %0d translations (%0d hits)",
			load_map.loads, load_map.translations, load_map.hits);
		$display("segment count written %0d times, including 0 and 15", count_settings);
		if (load_map.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
